[design/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("check failed: label");

// Implication checked only in cycles where cond holds
`define CHK_ON(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error("check failed: label");

`endif

[design/tsad_pkg.sv]
// Package for the aggregating deque: sizes, codes and the fold operator.
// No dependencies.
`timescale 1ns / 1ps
package tsad_pkg;
	// capacity must be a power of two: slot indexes wrap by truncation
	localparam int CAPACITY   = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int AW         = $clog2(CAPACITY);
	localparam int CW         = AW + 1;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [AW-1:0]         slot_t;
	typedef logic [CW-1:0]         cnt_t;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_BACK   = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_READ       = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_MIN   = 3'd1,
		OP_MAX   = 3'd2,
		OP_AND   = 3'd3,
		OP_OR    = 3'd4,
		OP_XOR   = 3'd5,
		OP_LEFT  = 3'd6,
		OP_RIGHT = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_RD_DATA, S_WALK_RD, S_WALK_WR,
		S_REF_F, S_REF_B, S_REF_END, S_DONE
	} state_t;

	// write and read controls from the sequencer to the store
	typedef struct packed {
		logic  we_elem;
		logic  we_part;
		slot_t waddr;
		data_t welem;
		data_t wpart;
		slot_t raddr;
	} mem_ctl_t;

	function automatic data_t combine(input logic [2:0] op, input data_t a, input data_t b);
		data_t r;
		case (op)
			OP_ADD:   r = a + b;
			OP_MIN:   r = (a < b) ? a : b;
			OP_MAX:   r = (a > b) ? a : b;
			OP_AND:   r = a & b;
			OP_OR:    r = a | b;
			OP_XOR:   r = a ^ b;
			OP_LEFT:  r = a;
			default:  r = b;
		endcase
		return r;
	endfunction
endpackage

[design/tsad_if.sv]
// Channel interfaces: request, response and configuration write.
// No dependencies.
`timescale 1ns / 1ps
interface tsad_req_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               mode;
	logic [31:0]              push_value;
	logic [9:0]               read_index;
	modport source (output valid, mode, push_value, read_index, input ready);
	modport sink   (input valid, mode, push_value, read_index, output ready);
endinterface

interface tsad_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] read_data;
	logic [31:0] total;
	logic [31:0] front_value;
	logic [31:0] back_value;
	logic [10:0] count;
	logic        is_empty;
	modport source (output valid, status, read_data, total, front_value, back_value,
		count, is_empty, input ready);
	modport sink   (input valid, status, read_data, total, front_value, back_value,
		count, is_empty, output ready);
endinterface

interface tsad_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[design/tsad_store.sv]
// Element and partial-fold memories, one write and one registered read each.
// Depends on tsad_pkg.
`timescale 1ns / 1ps
module tsad_store (
	input  logic             clk,
	input  tsad_pkg::mem_ctl_t ctl,
	output tsad_pkg::data_t  relem,
	output tsad_pkg::data_t  rpart
);
	import tsad_pkg::*;

	data_t elem_mem [CAPACITY];
	data_t part_mem [CAPACITY];

	// element memory
	always_ff @(posedge clk) begin
		if (ctl.we_elem) begin
			elem_mem[ctl.waddr] <= ctl.welem;
		end
		relem <= elem_mem[ctl.raddr];
	end

	// partial fold memory
	always_ff @(posedge clk) begin
		if (ctl.we_part) begin
			part_mem[ctl.waddr] <= ctl.wpart;
		end
		rpart <= part_mem[ctl.raddr];
	end
endmodule

[design/two_stack_aggregating_deque_top.sv]
// Top level of the aggregating deque: sequencer, cached ends, result register.
// Depends on tsad_pkg, tsad_if, tsad_store.
//
// Usage: req carries one operation per item (push back/front, pop back/front,
// read by index). rsp returns one item per request with status, read data,
// fold of all elements, front, back, count and empty flag. cfg writes the
// fold operator; write it only while no request is in flight.
// Steps: a push goes from acceptance through execute to done; an in-range read
// by index adds a memory read state; a pop that removes an element refetches
// both cached ends from memory. A pop that finds its own side empty first
// rebuilds the partial folds of both halves, one memory read and one combine
// and write per element. One item is in work at a time; the next is accepted
// in the idle state that follows registering the previous result. The single
// read port of each memory serialises end refetches and rebuild reads.
// Reset clears pointers, counts and operator; the memories are not cleared
// and no clearing pass runs. A stalled receiver holds the result register;
// a finished item then waits in the done state until the register frees.
`timescale 1ns / 1ps
module two_stack_aggregating_deque_top (
	input logic       clk,
	input logic       arst_n,
	tsad_req_if.sink  req,
	tsad_rsp_if.source rsp,
	tsad_cfg_if.sink  cfg
);
	import tsad_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] mode_q, op_q;
	data_t      val_q, acc_q, rd_q;
	slot_t      idx_q, front_q, back_q, addr_q;
	cnt_t       lc_q, rc_q, rem_q, cnt;
	data_t      ef_q, eb_q, pf_q, pb_q;
	status_t    st_q;
	logic       first_q, left_q, ov_q;
	data_t      relem, rpart, walk_v, push_v, total_v;
	mem_ctl_t   ctl;
	// pop bookkeeping
	slot_t      nfront, nback;
	cnt_t       nlc, nrc;
	logic       rebuild, out_free;

	tsad_store u_store (.clk(clk), .ctl(ctl), .relem(relem), .rpart(rpart));

	assign cnt      = lc_q + rc_q;
	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// pop pointer and count updates, including the half split
	always_comb begin
		nfront  = front_q;
		nback   = back_q;
		nlc     = lc_q;
		nrc     = rc_q;
		rebuild = 1'b0;
		if (mode_q == MODE_POP_BACK) begin
			nback = back_q - slot_t'(1);
			if (rc_q == '0) begin
				rebuild = 1'b1;
				nrc = lc_q >> 1;
				nlc = (lc_q - cnt_t'(1)) >> 1;
			end else begin
				nrc = rc_q - cnt_t'(1);
			end
		end else begin
			nfront = front_q + slot_t'(1);
			if (lc_q == '0) begin
				rebuild = 1'b1;
				nlc = rc_q >> 1;
				nrc = (rc_q - cnt_t'(1)) >> 1;
			end else begin
				nlc = lc_q - cnt_t'(1);
			end
		end
	end

	// combine values for push, rebuild and the total
	always_comb begin
		if (mode_q == MODE_PUSH_BACK) begin
			push_v = (rc_q != '0) ? combine(op_q, pb_q, val_q) : val_q;
		end else begin
			push_v = (lc_q != '0) ? combine(op_q, val_q, pf_q) : val_q;
		end
		if (first_q) begin
			walk_v = relem;
		end else if (left_q) begin
			walk_v = combine(op_q, relem, acc_q);
		end else begin
			walk_v = combine(op_q, acc_q, relem);
		end
		if (lc_q != '0 && rc_q != '0) begin
			total_v = combine(op_q, pf_q, pb_q);
		end else if (lc_q != '0) begin
			total_v = pf_q;
		end else if (rc_q != '0) begin
			total_v = pb_q;
		end else begin
			total_v = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (mode_q)
					MODE_PUSH_BACK, MODE_PUSH_FRONT: state_d = S_DONE;
					MODE_POP_BACK, MODE_POP_FRONT: begin
						if (cnt == '0) state_d = S_DONE;
						else if (rebuild && (nrc != '0 || nlc != '0)) state_d = S_WALK_RD;
						else state_d = S_REF_F;
					end
					MODE_READ: begin
						if ({1'b0, idx_q} >= cnt) state_d = S_DONE;
						else state_d = S_RD_DATA;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RD_DATA: state_d = S_DONE;
			S_WALK_RD: state_d = S_WALK_WR;
			S_WALK_WR: begin
				if (rem_q != cnt_t'(1)) state_d = S_WALK_RD;
				else if (!left_q && lc_q != '0) state_d = S_WALK_RD;
				else state_d = S_REF_F;
			end
			S_REF_F:   state_d = S_REF_B;
			S_REF_B:   state_d = S_REF_END;
			S_REF_END: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ctl = '0;
		ctl.raddr = front_q;
		case (state_q)
			S_EXEC: begin
				if (cnt != cnt_t'(CAPACITY)) begin
					if (mode_q == MODE_PUSH_BACK) begin
						ctl.we_elem = 1'b1;
						ctl.we_part = 1'b1;
						ctl.waddr   = back_q + slot_t'(1);
					end else if (mode_q == MODE_PUSH_FRONT) begin
						ctl.we_elem = 1'b1;
						ctl.we_part = 1'b1;
						ctl.waddr   = front_q - slot_t'(1);
					end
				end
				ctl.welem = val_q;
				ctl.wpart = push_v;
				ctl.raddr = front_q + idx_q;
			end
			S_WALK_RD: ctl.raddr = addr_q;
			S_WALK_WR: begin
				ctl.we_part = 1'b1;
				ctl.waddr   = addr_q;
				ctl.wpart   = walk_v;
			end
			S_REF_F: ctl.raddr = front_q;
			S_REF_B: ctl.raddr = back_q;
			default: ctl.raddr = front_q;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ADD;
			front_q <= '0;
			back_q  <= slot_t'(CAPACITY - 1);
			lc_q    <= '0;
			rc_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) op_q <= cfg.data;
			if (state_q == S_DONE && out_free) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			if (state_q == S_EXEC) begin
				if (cnt != cnt_t'(CAPACITY) && mode_q == MODE_PUSH_BACK) begin
					back_q <= back_q + slot_t'(1);
					rc_q   <= rc_q + cnt_t'(1);
				end
				if (cnt != cnt_t'(CAPACITY) && mode_q == MODE_PUSH_FRONT) begin
					front_q <= front_q - slot_t'(1);
					lc_q    <= lc_q + cnt_t'(1);
				end
				if (cnt != '0 && (mode_q == MODE_POP_BACK || mode_q == MODE_POP_FRONT)) begin
					front_q <= nfront;
					back_q  <= nback;
					lc_q    <= nlc;
					rc_q    <= nrc;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= req.mode;
				val_q  <= req.push_value;
				idx_q  <= req.read_index;
				rd_q   <= '0;
				st_q   <= ST_OK;
			end
			S_EXEC: begin
				case (mode_q)
					MODE_PUSH_BACK: begin
						if (cnt == cnt_t'(CAPACITY)) begin
							st_q <= ST_FULL;
						end else begin
							eb_q <= val_q;
							pb_q <= push_v;
							if (cnt == '0) ef_q <= val_q;
						end
					end
					MODE_PUSH_FRONT: begin
						if (cnt == cnt_t'(CAPACITY)) begin
							st_q <= ST_FULL;
						end else begin
							ef_q <= val_q;
							pf_q <= push_v;
							if (cnt == '0) eb_q <= val_q;
						end
					end
					MODE_POP_BACK, MODE_POP_FRONT: begin
						if (cnt == '0) st_q <= ST_EMPTY;
						first_q <= 1'b1;
						if (nrc != '0) begin
							left_q <= 1'b0;
							addr_q <= nback - slot_t'(nrc - cnt_t'(1));
							rem_q  <= nrc;
						end else begin
							left_q <= 1'b1;
							addr_q <= nfront + slot_t'(nlc - cnt_t'(1));
							rem_q  <= nlc;
						end
					end
					MODE_READ: begin
						if ({1'b0, idx_q} >= cnt) st_q <= ST_RANGE;
					end
					default: st_q <= ST_OK;
				endcase
			end
			S_RD_DATA: rd_q <= relem;
			S_WALK_WR: begin
				acc_q <= walk_v;
				if (rem_q == cnt_t'(1)) begin
					// a half is done: after the right half, start the left half from its inner end
					left_q  <= 1'b1;
					first_q <= 1'b1;
					addr_q  <= front_q + slot_t'(lc_q - cnt_t'(1));
					rem_q   <= lc_q;
				end else begin
					first_q <= 1'b0;
					rem_q   <= rem_q - cnt_t'(1);
					addr_q  <= left_q ? addr_q - slot_t'(1) : addr_q + slot_t'(1);
				end
			end
			S_REF_B: begin
				ef_q <= relem;
				pf_q <= rpart;
			end
			S_REF_END: begin
				eb_q <= relem;
				pb_q <= rpart;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp.status      <= st_q;
			rsp.read_data   <= rd_q;
			rsp.total       <= total_v;
			rsp.front_value <= (cnt != '0) ? ef_q : '0;
			rsp.back_value  <= (cnt != '0) ? eb_q : '0;
			rsp.count       <= cnt;
			rsp.is_empty    <= (cnt == '0);
		end
	end

	assign rsp.valid = ov_q;
endmodule

[design/tsad_checker.sv]
// Port-level checks on the aggregating deque result channel, bound to the top.
// Depends on assert_macros.svh, tsad_pkg and two_stack_aggregating_deque_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic [1:0]  status,
	input logic [31:0] read_data,
	input logic [31:0] total,
	input logic [31:0] front_value,
	input logic [10:0] count,
	input logic        is_empty
);
	import tsad_pkg::*;

	`CHK_ON(a_empty_flag, clk, arst_n, rsp_valid, is_empty == (count == 11'd0))
	`CHK_ON(a_full_reject, clk, arst_n, rsp_valid && status == ST_FULL, count == 11'(CAPACITY))
	`CHK_ON(a_empty_reject, clk, arst_n, rsp_valid && status == ST_EMPTY, is_empty)
	`CHK_ON(a_range_zero, clk, arst_n, rsp_valid && status == ST_RANGE, read_data == 32'd0)
	`CHK_ON(a_empty_zero, clk, arst_n, rsp_valid && is_empty, total == 32'd0 && front_value == 32'd0)
endmodule

bind two_stack_aggregating_deque_top tsad_checker u_tsad_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid),
	.status(rsp.status), .read_data(rsp.read_data), .total(rsp.total),
	.front_value(rsp.front_value), .count(rsp.count), .is_empty(rsp.is_empty)
);
